// ----- rtl/lcd4_pkg.sv -----
// shared types, codes and the power-up byte table for the 4-bit character lcd interface
// no dependencies; imported by lcd4_cfg, lcd4_seq and char_lcd_4bit_interface_core
package lcd4_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_ENABLE_TICKS     = 3'd0;
    localparam logic [2:0] REG_SHORT_GAP        = 3'd1;
    localparam logic [2:0] REG_CLEAR_GAP        = 3'd2;
    localparam logic [2:0] REG_POWERUP          = 3'd3;
    localparam logic [2:0] REG_FIRST_RESET_GAP  = 3'd4;
    localparam logic [2:0] REG_LATER_RESET_GAP  = 3'd5;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 20;
    localparam int TICK_W      = 20;

    // register reset values
    localparam logic [9:0]  RST_ENABLE_TICKS    = 10'd10;
    localparam logic [15:0] RST_SHORT_GAP       = 16'd80;
    localparam logic [15:0] RST_CLEAR_GAP       = 16'd4000;
    localparam logic [19:0] RST_POWERUP         = 20'd100000;
    localparam logic [15:0] RST_FIRST_RESET_GAP = 16'd10000;
    localparam logic [15:0] RST_LATER_RESET_GAP = 16'd200;

    // sequencer phase codes
    localparam logic [1:0] PH_WAIT = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;
    localparam logic [1:0] PH_IDLE = 2'd3;

    // initialisation steps
    localparam logic [3:0] STEP_POWERUP    = 4'd0;
    localparam logic [3:0] STEP_RESET1     = 4'd1;
    localparam logic [3:0] STEP_RESET2     = 4'd2;
    localparam logic [3:0] STEP_RESET3     = 4'd3;
    localparam logic [3:0] STEP_MODE4      = 4'd4;
    localparam logic [3:0] STEP_FUNC_SET   = 4'd5;
    localparam logic [3:0] STEP_DISP_OFF   = 4'd6;
    localparam logic [3:0] STEP_CLEAR      = 4'd7;
    localparam logic [3:0] STEP_ENTRY_MODE = 4'd8;
    localparam logic [3:0] STEP_DISP_ON    = 4'd9;
    localparam logic [3:0] STEP_DONE       = 4'd10;

    localparam logic [7:0] CMD_CLEAR = 8'h01;

    typedef struct packed {
        logic [9:0]  enable_ticks;
        logic [15:0] short_gap_ticks;
        logic [15:0] clear_gap_ticks;
        logic [19:0] powerup_ticks;
        logic [15:0] first_reset_gap_ticks;
        logic [15:0] later_reset_gap_ticks;
    } lcd4_cfg_t;

    typedef struct packed {
        logic       accepted;
        logic       busy_res;
        logic       enable_line;
        logic       rs_line;
        logic [3:0] bus_nibble;
    } lcd4_res_t;

    // byte sent at each initialisation step
    function automatic logic [7:0] init_byte(input logic [3:0] step);
        logic [7:0] b;
        b = 8'h00;
        case (step)
            STEP_RESET1, STEP_RESET2, STEP_RESET3: b = 8'h30;
            STEP_MODE4:      b = 8'h20;
            STEP_FUNC_SET:   b = 8'h28;
            STEP_DISP_OFF:   b = 8'h08;
            STEP_CLEAR:      b = 8'h01;
            STEP_ENTRY_MODE: b = 8'h06;
            STEP_DISP_ON:    b = 8'h0C;
            default:         b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/lcd4_cfg.sv -----
// timing configuration registers of the 4-bit character lcd interface
// depends on lcd4_pkg
module lcd4_cfg
    import lcd4_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output lcd4_cfg_t              cfg
);

    lcd4_cfg_t cfg_reg;

    // register write, out-of-range indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable_ticks          <= RST_ENABLE_TICKS;
            cfg_reg.short_gap_ticks       <= RST_SHORT_GAP;
            cfg_reg.clear_gap_ticks       <= RST_CLEAR_GAP;
            cfg_reg.powerup_ticks         <= RST_POWERUP;
            cfg_reg.first_reset_gap_ticks <= RST_FIRST_RESET_GAP;
            cfg_reg.later_reset_gap_ticks <= RST_LATER_RESET_GAP;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ENABLE_TICKS:    cfg_reg.enable_ticks          <= cfg_data[9:0];
                REG_SHORT_GAP:       cfg_reg.short_gap_ticks       <= cfg_data[15:0];
                REG_CLEAR_GAP:       cfg_reg.clear_gap_ticks       <= cfg_data[15:0];
                REG_POWERUP:         cfg_reg.powerup_ticks         <= cfg_data[19:0];
                REG_FIRST_RESET_GAP: cfg_reg.first_reset_gap_ticks <= cfg_data[15:0];
                REG_LATER_RESET_GAP: cfg_reg.later_reset_gap_ticks <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/lcd4_seq.sv -----
// tick sequencer: power-up sequence, nibble transfers with enable pulses and gaps
// depends on lcd4_pkg; result is taken combinationally from the next state
module lcd4_seq
    import lcd4_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic       func,
    input  logic [7:0] data_byte,
    input  logic       reg_select,
    input  lcd4_cfg_t  cfg,
    output lcd4_res_t  res
);

    logic [3:0]        init_step_reg, init_step_next;
    logic [1:0]        phase_reg, phase_next;
    logic [TICK_W-1:0] tick_count_reg, tick_count_next;
    logic [7:0]        held_byte_reg, held_byte_next;
    logic              held_rs_reg, held_rs_next;
    logic              low_nibble_reg, low_nibble_next;
    logic              single_reg, single_next;
    logic [3:0]        nibble_reg, nibble_next;
    logic              rs_out_reg, rs_out_next;
    logic              enable_reg, enable_next;

    logic              busy;
    logic              accept;
    logic [15:0]       gap_ticks;
    logic [TICK_W-1:0] wait_limit;
    logic              wait_done;
    logic              enable_done;
    logic [3:0]        step_inc;
    logic              start;
    logic [7:0]        start_byte;
    logic              start_rs;
    logic              start_single;

    assign busy        = (init_step_reg < STEP_DONE) || (phase_reg != PH_IDLE);
    assign accept      = func && !busy;
    assign step_inc    = init_step_reg + 4'd1;
    assign enable_done = tick_count_reg >= {{(TICK_W-10){1'b0}}, cfg.enable_ticks};
    assign wait_done   = tick_count_reg >= wait_limit;

    // gap after the transfer just finished
    always_comb
    begin
        gap_ticks = cfg.short_gap_ticks;
        if (init_step_reg < STEP_DONE)
        begin
            case (init_step_reg) inside
                STEP_RESET1:              gap_ticks = cfg.first_reset_gap_ticks;
                STEP_RESET2, STEP_RESET3: gap_ticks = cfg.later_reset_gap_ticks;
                STEP_CLEAR:               gap_ticks = cfg.clear_gap_ticks;
                default:                  gap_ticks = cfg.short_gap_ticks;
            endcase
        end
        else if (!held_rs_reg && held_byte_reg == CMD_CLEAR)
        begin
            gap_ticks = cfg.clear_gap_ticks;
        end
    end

    assign wait_limit = (init_step_reg == STEP_POWERUP) ? cfg.powerup_ticks
                                                        : {{(TICK_W-16){1'b0}}, gap_ticks};

    // next state for one tick
    always_comb
    begin
        init_step_next  = init_step_reg;
        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        held_byte_next  = held_byte_reg;
        held_rs_next    = held_rs_reg;
        low_nibble_next = low_nibble_reg;
        single_next     = single_reg;
        nibble_next     = nibble_reg;
        rs_out_next     = rs_out_reg;
        enable_next     = enable_reg;
        start           = 1'b0;
        start_byte      = data_byte;
        start_rs        = reg_select;
        start_single    = 1'b0;

        if (accept)
        begin
            start = 1'b1;
        end
        else
        begin
            unique case (phase_reg)
                PH_WAIT:
                begin
                    if (wait_done)
                    begin
                        if (init_step_reg < STEP_DONE)
                        begin
                            init_step_next = step_inc;
                        end
                        if (init_step_reg < STEP_DISP_ON)
                        begin
                            start        = 1'b1;
                            start_byte   = init_byte(step_inc);
                            start_rs     = 1'b0;
                            start_single = (step_inc <= STEP_MODE4);
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    else
                    begin
                        tick_count_next = tick_count_reg + 1'b1;
                    end
                end
                PH_HIGH:
                begin
                    if (enable_done)
                    begin
                        enable_next     = 1'b0;
                        phase_next      = PH_LOW;
                        tick_count_next = {{(TICK_W-1){1'b0}}, 1'b1};
                    end
                    else
                    begin
                        tick_count_next = tick_count_reg + 1'b1;
                    end
                end
                PH_LOW:
                begin
                    if (enable_done)
                    begin
                        if (!single_reg && !low_nibble_reg)
                        begin
                            low_nibble_next = 1'b1;
                            nibble_next     = held_byte_reg[3:0];
                            enable_next     = 1'b1;
                            phase_next      = PH_HIGH;
                        end
                        else
                        begin
                            phase_next = PH_WAIT;
                        end
                        tick_count_next = {{(TICK_W-1){1'b0}}, 1'b1};
                    end
                    else
                    begin
                        tick_count_next = tick_count_reg + 1'b1;
                    end
                end
                PH_IDLE: ;
                default: ;
            endcase
        end

        // begin a transfer with the high nibble
        if (start)
        begin
            held_byte_next  = start_byte;
            held_rs_next    = start_rs;
            single_next     = start_single;
            low_nibble_next = 1'b0;
            nibble_next     = start_byte[7:4];
            rs_out_next     = start_rs;
            enable_next     = 1'b1;
            phase_next      = PH_HIGH;
            tick_count_next = {{(TICK_W-1){1'b0}}, 1'b1};
        end
    end

    // state update on each tick transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_step_reg  <= STEP_POWERUP;
            phase_reg      <= PH_WAIT;
            tick_count_reg <= '0;
            held_byte_reg  <= '0;
            held_rs_reg    <= 1'b0;
            low_nibble_reg <= 1'b0;
            single_reg     <= 1'b0;
            nibble_reg     <= '0;
            rs_out_reg     <= 1'b0;
            enable_reg     <= 1'b0;
        end
        else if (step)
        begin
            init_step_reg  <= init_step_next;
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            held_byte_reg  <= held_byte_next;
            held_rs_reg    <= held_rs_next;
            low_nibble_reg <= low_nibble_next;
            single_reg     <= single_next;
            nibble_reg     <= nibble_next;
            rs_out_reg     <= rs_out_next;
            enable_reg     <= enable_next;
        end
    end

    // line levels after this tick
    assign res.bus_nibble  = nibble_next;
    assign res.rs_line     = rs_out_next;
    assign res.enable_line = enable_next;
    assign res.busy_res    = (init_step_next < STEP_DONE) || (phase_next != PH_IDLE);
    assign res.accepted    = accept;

endmodule

// ----- rtl/char_lcd_4bit_interface_core.sv -----
// top level of the 4-bit character lcd interface: stream ports, input and result registers
// depends on lcd4_pkg, lcd4_cfg and lcd4_seq
//
// Each input transaction is one timer tick, optionally carrying a write request, and
// produces exactly one result transaction with the lcd line levels after that tick.
// The block takes one tick per clock cycle while the result side does not stall; a tick
// passes through an input register, is applied to the sequencer state and lands in the
// result register, from which its result is offered. Stalls on the result side hold
// the pipeline without losing ticks. After reset the block runs the power-up sequence
// (reset nibbles, 4-bit mode, function set, display off, clear, entry mode, display on)
// counted in ticks; requests made while busy are dropped with accepted low. Timing
// registers should only be written while no ticks are in flight.
module char_lcd_4bit_interface_core
    import lcd4_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,  // data_byte[7:0]
    input  logic [1:0]             s_axis_tuser,  // func[0], reg_select[1]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [7:0]             m_axis_tdata,  // bus_nibble[3:0], rs_line[4],
                                                  // enable_line[5], busy_res[6], accepted[7]
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic       in_valid_reg;
    logic       in_func_reg;
    logic [7:0] in_byte_reg;
    logic       in_rs_reg;
    logic       out_valid_reg;
    lcd4_res_t  out_res_reg;
    logic       step;
    lcd4_cfg_t  cfg;
    lcd4_res_t  res;

    assign step          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;

    lcd4_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lcd4_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .func       (in_func_reg),
        .data_byte  (in_byte_reg),
        .reg_select (in_rs_reg),
        .cfg        (cfg),
        .res        (res)
    );

    // input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_func_reg <= s_axis_tuser[0];
            in_rs_reg   <= s_axis_tuser[1];
            in_byte_reg <= s_axis_tdata;
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_res_reg.accepted, out_res_reg.busy_res,
                            out_res_reg.enable_line, out_res_reg.rs_line,
                            out_res_reg.bus_nibble};

`ifndef SYNTHESIS
    // a processed tick always leaves a result behind
    a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("processed tick produced no result");

    // a taken request starts a transfer with enable high
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.accepted |-> res.enable_line && res.busy_res)
        else $error("accepted request did not start a transfer");

    // input side stalls only while a tick is held
    a_ready_low_held: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg && out_valid_reg && !m_axis_tready)
        else $error("input stalled without a held tick");
`endif

endmodule

// ----- tb/tb_char_lcd_4bit_interface_core.sv -----
// self-checking testbench for char_lcd_4bit_interface_core: tick stream in, line levels out
// depends on lcd4_pkg and the rtl of the core; a built-in line predictor checks every result
// covers power-up, directed requests, random traffic and full-scale timing registers
module tb_char_lcd_4bit_interface_core;
    import lcd4_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 4000;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd6;

    // bytes sent by each power-up step, step 0 is the power-up wait
    localparam logic [0:9][7:0] POWER_UP_BYTES =
        {8'h00, 8'h30, 8'h30, 8'h30, 8'h20, 8'h28, 8'h08, 8'h01, 8'h06, 8'h0C};

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
        logic       reg_select;
    } lcd_tick_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = '0;   // data_byte[7:0]
    logic [1:0]             s_axis_tuser = '0;   // func[0], reg_select[1]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [7:0]             m_axis_tdata;        // bus_nibble[3:0], rs_line[4],
                                                 // enable_line[5], busy_res[6], accepted[7]
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // predictor state and its copy of the timing registers
    lcd4_cfg_t   lcd_cfg;
    logic [3:0]  seq_step;
    logic [1:0]  seq_phase;
    logic [19:0] seq_count;
    logic [7:0]  held_byte;
    logic        held_rs;
    logic        low_half_next;
    logic        one_nibble;
    logic [3:0]  line_nibble;
    logic        line_rs;
    logic        line_en;

    lcd_tick_t pending_ticks[$];
    lcd4_res_t expected_lines[$];

    int  fail_count = 0;
    int  ticks_queued = 0;
    int  ticks_taken = 0;
    int  results_seen = 0;
    int  taken_requests = 0;
    int  dropped_requests = 0;
    int  reg_writes = 0;
    int  tx_gap = 0;
    int  rx_gap = 0;
    int  hold_left = 0;
    int  hold_asked = 0;
    int  hold_served = 0;
    int  quiet_cycles = 0;
    logic tx_taken = 1'b0;
    logic no_idle = 1'b0;

    char_lcd_4bit_interface_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // zero in an enable or gap register behaves as one tick
    function automatic int eff(input int v);
        return (v == 0) ? 1 : v;
    endfunction

    // idle length for either side: mostly none, some short, a few long
    function automatic int idle_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ticks after the accepting tick until the block is idle again
    function automatic int transfer_len(input logic [7:0] b, input logic rs);
        int gap;
        gap = (!rs && b == CMD_CLEAR) ? int'(lcd_cfg.clear_gap_ticks)
                                      : int'(lcd_cfg.short_gap_ticks);
        return 4 * eff(int'(lcd_cfg.enable_ticks)) + eff(gap);
    endfunction

    function automatic void load_transfer(input logic [7:0] b, input logic rs,
                                          input logic single);
        held_byte     = b;
        held_rs       = rs;
        one_nibble    = single;
        low_half_next = 1'b0;
        line_nibble   = b[7:4];
        line_rs       = rs;
        line_en       = 1'b1;
        seq_phase     = PH_HIGH;
        seq_count     = 20'd1;
    endfunction

    // advance the line predictor by one tick and return the line levels after it
    function automatic lcd4_res_t lcd_line_step(input lcd_tick_t t);
        lcd4_res_t   r;
        logic [19:0] limit;
        r = '0;
        limit = '0;
        if (t.func && seq_step == STEP_DONE && seq_phase == PH_IDLE)
        begin
            load_transfer(t.data_byte, t.reg_select, 1'b0);
            r.accepted = 1'b1;
        end
        else
        begin
            case (seq_phase)
                PH_WAIT:
                begin
                    if (seq_step == STEP_POWERUP)
                        limit = lcd_cfg.powerup_ticks;
                    else if (seq_step == STEP_RESET1)
                        limit = 20'(lcd_cfg.first_reset_gap_ticks);
                    else if (seq_step == STEP_RESET2 || seq_step == STEP_RESET3)
                        limit = 20'(lcd_cfg.later_reset_gap_ticks);
                    else if (seq_step == STEP_CLEAR || (seq_step == STEP_DONE && !held_rs
                             && held_byte == CMD_CLEAR))
                        limit = 20'(lcd_cfg.clear_gap_ticks);
                    else
                        limit = 20'(lcd_cfg.short_gap_ticks);
                    if (seq_count >= limit)
                    begin
                        if (seq_step != STEP_DONE)
                            seq_step = seq_step + 4'd1;
                        if (seq_step != STEP_DONE)
                            load_transfer(POWER_UP_BYTES[seq_step], 1'b0,
                                          seq_step <= STEP_MODE4);
                        else
                            seq_phase = PH_IDLE;
                    end
                    else
                        seq_count = seq_count + 20'd1;
                end
                PH_HIGH:
                begin
                    if (seq_count >= 20'(lcd_cfg.enable_ticks))
                    begin
                        line_en   = 1'b0;
                        seq_phase = PH_LOW;
                        seq_count = 20'd1;
                    end
                    else
                        seq_count = seq_count + 20'd1;
                end
                PH_LOW:
                begin
                    if (seq_count >= 20'(lcd_cfg.enable_ticks))
                    begin
                        if (!one_nibble && !low_half_next)
                        begin
                            low_half_next = 1'b1;
                            line_nibble   = held_byte[3:0];
                            line_en       = 1'b1;
                            seq_phase     = PH_HIGH;
                        end
                        else
                            seq_phase = PH_WAIT;
                        seq_count = 20'd1;
                    end
                    else
                        seq_count = seq_count + 20'd1;
                end
                default: ;
            endcase
        end
        r.busy_res    = (seq_step != STEP_DONE) || (seq_phase != PH_IDLE);
        r.bus_nibble  = line_nibble;
        r.rs_line     = line_rs;
        r.enable_line = line_en;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input int got, input int want);
        fail_count++;
        if (fail_count <= 30)
            $display("mismatch at result %0d: %s is %0d, expected %0d",
                     results_seen, what, got, want);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [19:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        reg_writes++;
    endtask

    task automatic queue_tick(input logic func, input logic [7:0] b, input logic rs);
        lcd_tick_t t;
        t.func       = func;
        t.data_byte  = b;
        t.reg_select = rs;
        pending_ticks.push_back(t);
        ticks_queued++;
    endtask

    // ticks with random content, req_pct percent of them carrying a request
    task automatic queue_random_ticks(input int n, input int req_pct);
        for (int i = 0; i < n; i++)
            queue_tick($urandom_range(0, 99) < req_pct, 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)));
    endtask

    // one request followed by exactly the ticks it keeps the block busy
    task automatic queue_transfer(input logic [7:0] b, input logic rs);
        queue_tick(1'b1, b, rs);
        queue_random_ticks(transfer_len(b, rs), 25);
    endtask

    // sender pause: nothing pending, nothing in flight
    task automatic wait_drained();
        while (pending_ticks.size() != 0 || s_axis_tvalid || expected_lines.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // input driver: one tick transaction at a time, gaps between them
    always @(negedge clk)
    begin : drive_ticks
        lcd_tick_t t;
        if (rst_n && !(s_axis_tvalid && !tx_taken))
        begin
            if (tx_gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                tx_gap        <= tx_gap - 1;
            end
            else if (pending_ticks.size() != 0)
            begin
                t = pending_ticks.pop_front();
                s_axis_tdata  <= t.data_byte;
                s_axis_tuser  <= {t.reg_select, t.func};
                s_axis_tvalid <= 1'b1;
                tx_gap        <= idle_gap();
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // result side ready: random stalls plus long hold-offs on request
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left     <= hold_left - 1;
            end
            else if (hold_asked != hold_served)
            begin
                m_axis_tready <= 1'b0;
                hold_left     <= HOLD_CYCLES;
                hold_served   <= hold_asked;
            end
            else if (rx_gap > 0)
            begin
                m_axis_tready <= 1'b0;
                rx_gap        <= rx_gap - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                rx_gap        <= idle_gap();
            end
        end
    end

    // monitor: register writes, tick transactions into the predictor, results checked
    always @(posedge clk)
    begin : monitor
        lcd_tick_t seen;
        lcd4_res_t got;
        lcd4_res_t want;
        if (rst_n)
        begin
            tx_taken <= s_axis_tvalid && s_axis_tready;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ENABLE_TICKS:    lcd_cfg.enable_ticks          = cfg_data[9:0];
                    REG_SHORT_GAP:       lcd_cfg.short_gap_ticks       = cfg_data[15:0];
                    REG_CLEAR_GAP:       lcd_cfg.clear_gap_ticks       = cfg_data[15:0];
                    REG_POWERUP:         lcd_cfg.powerup_ticks         = cfg_data[19:0];
                    REG_FIRST_RESET_GAP: lcd_cfg.first_reset_gap_ticks = cfg_data[15:0];
                    REG_LATER_RESET_GAP: lcd_cfg.later_reset_gap_ticks = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                seen.func       = s_axis_tuser[0];
                seen.reg_select = s_axis_tuser[1];
                seen.data_byte  = s_axis_tdata;
                want = lcd_line_step(seen);
                expected_lines.push_back(want);
                ticks_taken++;
                if (seen.func && want.accepted)
                    taken_requests++;
                else if (seen.func)
                    dropped_requests++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = lcd4_res_t'(m_axis_tdata);
                results_seen++;
                if (expected_lines.size() == 0)
                    note_mismatch("result with nothing outstanding, data", m_axis_tdata, 0);
                else
                begin
                    want = expected_lines.pop_front();
                    if (got.bus_nibble !== want.bus_nibble)
                        note_mismatch("bus_nibble", got.bus_nibble, want.bus_nibble);
                    if (got.rs_line !== want.rs_line)
                        note_mismatch("rs_line", got.rs_line, want.rs_line);
                    if (got.enable_line !== want.enable_line)
                        note_mismatch("enable_line", got.enable_line, want.enable_line);
                    if (got.busy_res !== want.busy_res)
                        note_mismatch("busy_res", got.busy_res, want.busy_res);
                    if (got.accepted !== want.accepted)
                        note_mismatch("accepted", got.accepted, want.accepted);
                end
            end
        end
    end

    // watchdog: too long without any transaction or register write
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("no transaction for %0d cycles, %0d results outstanding",
                         quiet_cycles, expected_lines.size());
                $display("Test completed with failures");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus and end of run
    initial
    begin : stimulus
        int n;
        int phase_start;
        int longest;
        logic [7:0] b;
        logic rs;

        // predictor at its reset state
        lcd_cfg.enable_ticks          = RST_ENABLE_TICKS;
        lcd_cfg.short_gap_ticks       = RST_SHORT_GAP;
        lcd_cfg.clear_gap_ticks       = RST_CLEAR_GAP;
        lcd_cfg.powerup_ticks         = RST_POWERUP;
        lcd_cfg.first_reset_gap_ticks = RST_FIRST_RESET_GAP;
        lcd_cfg.later_reset_gap_ticks = RST_LATER_RESET_GAP;
        seq_step      = STEP_POWERUP;
        seq_phase     = PH_WAIT;
        seq_count     = '0;
        held_byte     = '0;
        held_rs       = 1'b0;
        low_half_next = 1'b0;
        one_nibble    = 1'b0;
        line_nibble   = '0;
        line_rs       = 1'b0;
        line_en       = 1'b0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // zero power-up wait, zero enable, short gap and later reset gap; zero enable and gaps act as one tick
        write_reg(REG_ENABLE_TICKS, 20'd0);
        write_reg(REG_SHORT_GAP, 20'd0);
        write_reg(REG_CLEAR_GAP, 20'd2);
        write_reg(REG_POWERUP, 20'd0);
        write_reg(REG_FIRST_RESET_GAP, 20'd3);
        write_reg(REG_LATER_RESET_GAP, 20'd0);
        @(posedge clk);

        // power-up sequence, requests during it are all dropped
        n = int'(lcd_cfg.powerup_ticks) + 1 + 28 * eff(int'(lcd_cfg.enable_ticks))
            + eff(int'(lcd_cfg.first_reset_gap_ticks))
            + 2 * eff(int'(lcd_cfg.later_reset_gap_ticks))
            + 5 * eff(int'(lcd_cfg.short_gap_ticks)) + eff(int'(lcd_cfg.clear_gap_ticks));
        queue_random_ticks(n, 40);
        queue_random_ticks(2, 0);

        // directed requests: byte extremes, clear command, 0x01 as a character
        queue_transfer(8'h00, 1'b0);
        queue_transfer(8'hFF, 1'b1);
        queue_transfer(CMD_CLEAR, 1'b0);
        queue_transfer(CMD_CLEAR, 1'b1);
        // a request on the tick the wait ends is dropped, the next one is taken
        queue_tick(1'b1, 8'hA5, 1'b0);
        queue_random_ticks(transfer_len(8'hA5, 1'b0) - 1, 0);
        queue_tick(1'b1, 8'h3C, 1'b1);
        queue_transfer(8'h5A, 1'b1);
        queue_random_ticks(1, 0);
        wait_drained();

        // random phases, each with its own register setting
        for (int p = 0; p < 6; p++)
        begin
            write_reg(REG_ENABLE_TICKS, (p == 0) ? 20'd1 : 20'($urandom_range(1, 3)));
            write_reg(REG_SHORT_GAP, (p == 4) ? 20'd1 : 20'($urandom_range(1, 12)));
            write_reg(REG_CLEAR_GAP, (p == 5) ? 20'd1 : 20'($urandom_range(2, 30)));
            // power-up registers no longer matter, but every data bit gets both values
            write_reg(REG_POWERUP, (p == 0) ? 20'hFFFFF : (p == 1) ? 20'h0
                                            : 20'($urandom_range(0, 20'hFFFFF)));
            write_reg(REG_FIRST_RESET_GAP, (p == 0) ? 20'hFFFF : (p == 1) ? 20'h0
                                                    : 20'($urandom_range(0, 16'hFFFF)));
            write_reg(REG_LATER_RESET_GAP, (p == 0) ? 20'hFFFF : (p == 1) ? 20'h0
                                                    : 20'($urandom_range(0, 16'hFFFF)));
            if (p == 5)
                write_reg(REG_SPARE, 20'($urandom_range(0, 20'hFFFFF)));
            @(posedge clk);
            no_idle = (p == 2);
            longest = 4 * eff(int'(lcd_cfg.enable_ticks))
                      + eff(int'(lcd_cfg.clear_gap_ticks))
                      + eff(int'(lcd_cfg.short_gap_ticks)) + 1;
            phase_start = ticks_queued;
            while (ticks_queued - phase_start < 215)
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    // well-formed request, occasionally the clear command
                    if ($urandom_range(0, 5) == 0)
                    begin
                        b  = CMD_CLEAR;
                        rs = 1'b0;
                    end
                    else
                    begin
                        b  = 8'($urandom_range(0, 255));
                        rs = 1'($urandom_range(0, 1));
                    end
                    queue_transfer(b, rs);
                    if ($urandom_range(0, 9) >= 7)
                        queue_random_ticks($urandom_range(1, 3), 0);
                end
                else
                begin
                    // noise with requests anywhere, then plain ticks to settle
                    queue_random_ticks($urandom_range(1, 2 * longest), 50);
                    queue_random_ticks(longest, 0);
                end
            end
            if (p == 1)
            begin
                // long result stall while ticks keep coming
                repeat (30) @(posedge clk);
                hold_asked = hold_asked + 1;
            end
            wait_drained();
            no_idle = 1'b0;
        end

        // full-scale enable and gaps: a clear command and the start of its high nibble
        write_reg(REG_ENABLE_TICKS, 20'd1023);
        write_reg(REG_SHORT_GAP, 20'd65535);
        write_reg(REG_CLEAR_GAP, 20'd65535);
        @(posedge clk);
        no_idle = 1'b1;
        queue_tick(1'b1, CMD_CLEAR, 1'b0);
        queue_random_ticks(40, 25);
        wait_drained();
        no_idle = 1'b0;

        repeat (8) @(posedge clk);
        $display("%0d ticks checked over %0d register writes: %0d requests taken, %0d dropped",
                 results_seen, reg_writes, taken_requests, dropped_requests);
        $display("power-up, zero and full-scale timings, and a %0d-cycle result stall covered",
                 HOLD_CYCLES);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- char_lcd_4bit_interface_core.f -----
rtl/lcd4_pkg.sv
rtl/lcd4_cfg.sv
rtl/lcd4_seq.sv
rtl/char_lcd_4bit_interface_core.sv
tb/tb_char_lcd_4bit_interface_core.sv
